// ===== src/i2cgx_pkg.sv =====
// Package for the register side of the I2C port expander.
// Holds the command codes, bus operation codes and the state update struct.
// No dependencies.
package i2cgx_pkg;

    // Default width of the expander port.
    localparam int PORT_BITS_DEF = 8;

    // Width of a command byte and of the register pointer.
    localparam int CMD_W = 8;

    // Register pointer values and command codes.
    localparam logic [CMD_W-1:0] CMD_AWAIT     = 8'hFF;
    localparam logic [CMD_W-1:0] CMD_NONE      = 8'h00;
    localparam logic [CMD_W-1:0] CMD_OUTPUT    = 8'h01;
    localparam logic [CMD_W-1:0] CMD_POLARITY  = 8'h02;
    localparam logic [CMD_W-1:0] CMD_DIRECTION = 8'h03;

    // Bus operation carried with each byte.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Write enables for the state registers, one per register.
    typedef struct packed {
        logic ptr_we;
        logic pol_we;
        logic dir_we;
        logic drv_we;
        logic last_we;
    } i2cgx_upd_t;

endpackage

// ===== src/i2cgx_core.sv =====
// Combinational byte processing for the I2C port expander register side.
// Computes the next register values and the result fields for one bus byte.
// Depends on i2cgx_pkg.
module i2cgx_core #(
    parameter int PORT_BITS = i2cgx_pkg::PORT_BITS_DEF
) (
    input  logic                        operation,
    input  logic [i2cgx_pkg::CMD_W-1:0] write_data,
    input  logic [PORT_BITS-1:0]        pin_levels,
    input  logic                        power_on,
    input  logic [i2cgx_pkg::CMD_W-1:0] ptr,
    input  logic [PORT_BITS-1:0]        pol,
    input  logic [PORT_BITS-1:0]        dir,
    input  logic [PORT_BITS-1:0]        drv,
    input  logic [PORT_BITS-1:0]        last,
    output i2cgx_pkg::i2cgx_upd_t       upd,
    output logic [i2cgx_pkg::CMD_W-1:0] ptr_next,
    output logic [PORT_BITS-1:0]        pol_next,
    output logic [PORT_BITS-1:0]        dir_next,
    output logic [PORT_BITS-1:0]        drv_next,
    output logic [PORT_BITS-1:0]        last_next,
    output logic                        ack,
    output logic [PORT_BITS-1:0]        read_data,
    output logic [PORT_BITS-1:0]        pin_drive,
    output logic [PORT_BITS-1:0]        drive_enable,
    output logic                        int_pulse,
    output logic                        command_error
);
    import i2cgx_pkg::*;

    logic [PORT_BITS+CMD_W-1:0] data_ext;
    logic [PORT_BITS-1:0]       data_p;
    logic [PORT_BITS-1:0]       read_val;

    // Data byte fitted to the port width, and the value a read returns.
    assign data_ext = {{PORT_BITS{1'b0}}, write_data};
    assign data_p   = data_ext[PORT_BITS-1:0];
    assign read_val = (pin_levels ^ pol) & dir;

    // Byte decode: register updates and the acknowledge, read and error fields.
    always_comb
    begin
        upd           = '0;
        ptr_next      = ptr;
        pol_next      = pol;
        dir_next      = dir;
        drv_next      = drv;
        last_next     = last;
        ack           = 1'b0;
        read_data     = '0;
        int_pulse     = 1'b0;
        command_error = 1'b0;
        if (power_on)
        begin
            if (operation == OP_READ)
            begin
                read_data   = read_val;
                int_pulse   = (read_val != last);
                upd.last_we = int_pulse;
                last_next   = read_val;
                upd.ptr_we  = 1'b1;
                ptr_next    = CMD_AWAIT;
            end
            else
            begin
                ack = 1'b1;
                if (ptr == CMD_AWAIT)
                begin
                    upd.ptr_we = 1'b1;
                    ptr_next   = write_data;
                end
                else
                begin
                    unique case (ptr)
                        CMD_NONE:
                        begin
                            upd.ptr_we = 1'b1;
                            ptr_next   = CMD_AWAIT;
                        end
                        CMD_OUTPUT:
                        begin
                            upd.drv_we = 1'b1;
                            drv_next   = (drv & dir) | ((data_p ^ pol) & ~dir);
                            upd.ptr_we = 1'b1;
                            ptr_next   = CMD_AWAIT;
                        end
                        CMD_POLARITY:
                        begin
                            upd.pol_we = 1'b1;
                            pol_next   = data_p;
                            upd.ptr_we = 1'b1;
                            ptr_next   = CMD_AWAIT;
                        end
                        CMD_DIRECTION:
                        begin
                            upd.dir_we = 1'b1;
                            dir_next   = data_p;
                            upd.ptr_we = 1'b1;
                            ptr_next   = CMD_AWAIT;
                        end
                        default:
                        begin
                            // Unknown command stays selected and flags each data byte.
                            command_error = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    // Port outputs reflect the registers after this byte.
    assign pin_drive    = upd.drv_we ? drv_next : drv;
    assign drive_enable = upd.dir_we ? ~dir_next : ~dir;

endmodule

// ===== src/i2cgx_regs.sv =====
// State registers of the I2C port expander register side.
// Holds pointer, polarity, direction, driven levels and the last read value.
// Depends on i2cgx_pkg.
module i2cgx_regs #(
    parameter int PORT_BITS = i2cgx_pkg::PORT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  i2cgx_pkg::i2cgx_upd_t       upd,
    input  logic [i2cgx_pkg::CMD_W-1:0] ptr_next,
    input  logic [PORT_BITS-1:0]        pol_next,
    input  logic [PORT_BITS-1:0]        dir_next,
    input  logic [PORT_BITS-1:0]        drv_next,
    input  logic [PORT_BITS-1:0]        last_next,
    output logic [i2cgx_pkg::CMD_W-1:0] ptr,
    output logic [PORT_BITS-1:0]        pol,
    output logic [PORT_BITS-1:0]        dir,
    output logic [PORT_BITS-1:0]        drv,
    output logic [PORT_BITS-1:0]        last
);
    import i2cgx_pkg::*;

    logic [CMD_W-1:0]     ptr_reg;
    logic [PORT_BITS-1:0] pol_reg;
    logic [PORT_BITS-1:0] dir_reg;
    logic [PORT_BITS-1:0] drv_reg;
    logic [PORT_BITS-1:0] last_reg;

    // Each register loads when a byte is processed and its enable is set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= CMD_AWAIT;
            pol_reg  <= '0;
            dir_reg  <= '1;
            drv_reg  <= '0;
            last_reg <= '0;
        end
        else if (en)
        begin
            if (upd.ptr_we)
            begin
                ptr_reg <= ptr_next;
            end
            if (upd.pol_we)
            begin
                pol_reg <= pol_next;
            end
            if (upd.dir_we)
            begin
                dir_reg <= dir_next;
            end
            if (upd.drv_we)
            begin
                drv_reg <= drv_next;
            end
            if (upd.last_we)
            begin
                last_reg <= last_next;
            end
        end
    end

    assign ptr  = ptr_reg;
    assign pol  = pol_reg;
    assign dir  = dir_reg;
    assign drv  = drv_reg;
    assign last = last_reg;

endmodule

// ===== src/i2c_gpio_expander_registers_unit.sv =====
// Register side of an I2C port expander, one bus byte per transfer.
// Path: a transfer is captured in the input register, decoded, and its result is
// captured in the result register before it is presented. Throughput: one byte per
// cycle while the output is not stalled, set by the single decode stage.
// Reset: asynchronous, active low; pointer awaits a command, all pins inputs,
// polarity, driven levels and last read value cleared.
module i2c_gpio_expander_registers_unit #(
    parameter int PORT_BITS = i2cgx_pkg::PORT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // write_data, pin_levels, power_on, zero padding
    input  logic [((PORT_BITS+16)/8)*8-1:0]    s_tdata,
    // operation
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // ack, read_data, pin_drive, drive_enable, int_pulse, command_error, zero padding
    output logic [((3*PORT_BITS+10)/8)*8-1:0]  m_tdata
);
    import i2cgx_pkg::*;

    localparam int OUT_W    = 3 * PORT_BITS + 3;
    localparam int OUT_TDW  = ((3 * PORT_BITS + 10) / 8) * 8;

    // Input register.
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic                 in_op_reg;
    logic [CMD_W-1:0]     in_data_reg;
    logic [PORT_BITS-1:0] in_pins_reg;
    logic                 in_pwr_reg;

    // Result register.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_ack_reg;
    logic [PORT_BITS-1:0] out_rd_reg;
    logic [PORT_BITS-1:0] out_drv_reg;
    logic [PORT_BITS-1:0] out_en_reg;
    logic                 out_irq_reg;
    logic                 out_err_reg;

    // Decode results and state.
    i2cgx_upd_t           upd;
    logic [CMD_W-1:0]     ptr, ptr_next;
    logic [PORT_BITS-1:0] pol, pol_next;
    logic [PORT_BITS-1:0] dir, dir_next;
    logic [PORT_BITS-1:0] drv, drv_next;
    logic [PORT_BITS-1:0] last, last_next;
    logic                 c_ack;
    logic [PORT_BITS-1:0] c_rd;
    logic [PORT_BITS-1:0] c_drv;
    logic [PORT_BITS-1:0] c_en;
    logic                 c_irq;
    logic                 c_err;
    logic                 adv;

    // A byte moves from the input register to the result register.
    assign adv            = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || adv;
    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = adv ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Handshake control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload capture on each accepted transfer.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata[CMD_W-1:0];
            in_pins_reg <= s_tdata[CMD_W +: PORT_BITS];
            in_pwr_reg  <= s_tdata[CMD_W+PORT_BITS];
        end
    end

    i2cgx_core #(
        .PORT_BITS (PORT_BITS)
    ) u_core (
        .operation     (in_op_reg),
        .write_data    (in_data_reg),
        .pin_levels    (in_pins_reg),
        .power_on      (in_pwr_reg),
        .ptr           (ptr),
        .pol           (pol),
        .dir           (dir),
        .drv           (drv),
        .last          (last),
        .upd           (upd),
        .ptr_next      (ptr_next),
        .pol_next      (pol_next),
        .dir_next      (dir_next),
        .drv_next      (drv_next),
        .last_next     (last_next),
        .ack           (c_ack),
        .read_data     (c_rd),
        .pin_drive     (c_drv),
        .drive_enable  (c_en),
        .int_pulse     (c_irq),
        .command_error (c_err)
    );

    i2cgx_regs #(
        .PORT_BITS (PORT_BITS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .upd       (upd),
        .ptr_next  (ptr_next),
        .pol_next  (pol_next),
        .dir_next  (dir_next),
        .drv_next  (drv_next),
        .last_next (last_next),
        .ptr       (ptr),
        .pol       (pol),
        .dir       (dir),
        .drv       (drv),
        .last      (last)
    );

    // Result payload capture.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_ack_reg <= c_ack;
            out_rd_reg  <= c_rd;
            out_drv_reg <= c_drv;
            out_en_reg  <= c_en;
            out_irq_reg <= c_irq;
            out_err_reg <= c_err;
        end
    end

    // Result packing, first field in the lowest bits.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDW-OUT_W){1'b0}}, out_err_reg, out_irq_reg, out_en_reg,
                       out_drv_reg, out_rd_reg, out_ack_reg};

`ifndef SYNTH
    // State changes only when a byte is processed.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({ptr, pol, dir, drv, last}))
        else $error("expander state changed without a processed byte");

    // A command error only comes with an acknowledged write.
    a_err_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_err_reg) |-> out_ack_reg)
        else $error("command error without acknowledged write");

    // An interrupt pulse only comes from a read, which is never acknowledged.
    a_irq_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_irq_reg) |-> (!out_ack_reg && !out_err_reg))
        else $error("interrupt pulse on a write result");

    // With both registers full and the output stalled, no input is taken.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline is full");
`endif

endmodule

// ===== tb/sv/tb_i2c_gpio_expander_registers_unit.sv =====
// Self-checking testbench for the I2C port expander register unit.
// Drives bus bytes on the input stream, predicts every result transfer and
// compares it field by field. Depends on i2cgx_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_i2c_gpio_expander_registers_unit;
    import i2cgx_pkg::*;

    localparam int PB        = PORT_BITS_DEF;
    localparam int IN_W      = ((PB + 16) / 8) * 8;
    localparam int OUT_W     = ((3 * PB + 10) / 8) * 8;
    localparam int N_RANDOM  = 1750;
    localparam int MAX_CYCLES = 800000;
    localparam int MAX_PRINTS = 30;

    // One result transfer, unpacked.
    typedef struct packed {
        logic          ack;
        logic [PB-1:0] read_data;
        logic [PB-1:0] pin_drive;
        logic [PB-1:0] drive_enable;
        logic          int_pulse;
        logic          command_error;
    } port_result_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    // write_data, pin_levels, power_on, zero padding
    logic [IN_W-1:0]  s_tdata;
    // operation
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    // ack, read_data, pin_drive, drive_enable, int_pulse, command_error, zero padding
    logic [OUT_W-1:0] m_tdata;

    // Predicted register contents of the expander.
    logic [CMD_W-1:0] pred_pointer;
    logic [PB-1:0]    pred_polarity;
    logic [PB-1:0]    pred_direction;
    logic [PB-1:0]    pred_last_read;
    logic [PB-1:0]    pred_levels;

    port_result_t pending_results[$];

    int error_count;
    int bytes_sent;
    int results_seen;
    int reads_seen;
    int irq_seen;
    int cmd_err_seen;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int recv_stall_left;
    logic [PB-1:0] last_pins;

    i2c_gpio_expander_registers_unit #(
        .PORT_BITS (PB)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation, 10 ns period.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Cycle counter with a hard limit on the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTS)
        begin
            $display("%0d ns: %s mismatch, got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        end
        error_count++;
    endtask

    // Applies one bus byte to the predicted registers and returns the result.
    function automatic port_result_t predict_bus_byte(input logic op,
                                                      input logic [7:0] data,
                                                      input logic [PB-1:0] pins,
                                                      input logic powered);
        port_result_t r;
        logic [PB-1:0] value;
        logic [PB-1:0] outs;
        r = '0;
        if (powered)
        begin
            if (op == OP_READ)
            begin
                value = (pins ^ pred_polarity) & pred_direction;
                if (value != pred_last_read)
                begin
                    pred_last_read = value;
                    r.int_pulse = 1'b1;
                end
                pred_pointer = CMD_AWAIT;
                r.read_data = value;
            end
            else
            begin
                r.ack = 1'b1;
                if (pred_pointer == CMD_AWAIT)
                begin
                    pred_pointer = data;
                end
                else
                begin
                    case (pred_pointer)
                        CMD_NONE:
                        begin
                            pred_pointer = CMD_AWAIT;
                        end
                        CMD_OUTPUT:
                        begin
                            outs = ~pred_direction;
                            pred_levels = (pred_levels & ~outs)
                                        | ((PB'(data) ^ pred_polarity) & outs);
                            pred_pointer = CMD_AWAIT;
                        end
                        CMD_POLARITY:
                        begin
                            pred_polarity = PB'(data);
                            pred_pointer = CMD_AWAIT;
                        end
                        CMD_DIRECTION:
                        begin
                            pred_direction = PB'(data);
                            pred_pointer = CMD_AWAIT;
                        end
                        default:
                        begin
                            // Unknown command stays selected and flags each data byte.
                            r.command_error = 1'b1;
                        end
                    endcase
                end
            end
        end
        r.pin_drive = pred_levels;
        r.drive_enable = ~pred_direction;
        return r;
    endfunction

    // Random gap length: mostly short, now and then long.
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Sends one bus byte and queues its predicted result once accepted.
    task automatic send_byte(input logic op, input logic [7:0] data,
                             input logic [PB-1:0] pins, input logic powered);
        int gap;
        gap = pick_gap(send_idle_pct);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            s_tdata = '0;
            s_tdata[PB+7:0] = (PB+8)'($urandom);
            s_tuser = 1'($urandom_range(0, 1));
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = '0;
        s_tdata[7:0] = data;
        s_tdata[8 +: PB] = pins;
        s_tdata[8 + PB] = powered;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_bus_byte(op, data, pins, powered));
        bytes_sent++;
        if (op == OP_READ)
            reads_seen++;
    endtask

    // Byte with random pins; the supply drops out on about one byte in twenty.
    task automatic send_random_pins(input logic op, input logic [7:0] data);
        logic [PB-1:0] pins;
        pins = ($urandom_range(0, 1) == 0) ? last_pins : PB'($urandom);
        last_pins = pins;
        send_byte(op, data, pins, $urandom_range(0, 19) != 0);
    endtask

    // Result side: random stalls on tready, changed at the falling edge.
    always @(negedge clk)
    begin
        if (recv_stall_left > 0)
        begin
            m_tready = 1'b0;
            recv_stall_left--;
        end
        else
        begin
            m_tready = 1'b1;
            recv_stall_left = pick_gap(recv_idle_pct);
        end
    end

    // Compares each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        port_result_t got;
        port_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.ack           = m_tdata[0];
            got.read_data     = m_tdata[1 +: PB];
            got.pin_drive     = m_tdata[1 + PB +: PB];
            got.drive_enable  = m_tdata[1 + 2 * PB +: PB];
            got.int_pulse     = m_tdata[1 + 3 * PB];
            got.command_error = m_tdata[2 + 3 * PB];
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", 32'(m_tdata), 32'(0));
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                if (want.int_pulse)
                    irq_seen++;
                if (want.command_error)
                    cmd_err_seen++;
                if (got.ack != want.ack)
                    report_mismatch("ack", 32'(got.ack), 32'(want.ack));
                if (got.read_data != want.read_data)
                    report_mismatch("read_data", 32'(got.read_data),
                                    32'(want.read_data));
                if (got.pin_drive != want.pin_drive)
                    report_mismatch("pin_drive", 32'(got.pin_drive),
                                    32'(want.pin_drive));
                if (got.drive_enable != want.drive_enable)
                    report_mismatch("drive_enable", 32'(got.drive_enable),
                                    32'(want.drive_enable));
                if (got.int_pulse != want.int_pulse)
                    report_mismatch("int_pulse", 32'(got.int_pulse),
                                    32'(want.int_pulse));
                if (got.command_error != want.command_error)
                    report_mismatch("command_error", 32'(got.command_error),
                                    32'(want.command_error));
            end
        end
    end

    // Read right after reset, command bytes of 0xFF that keep the pointer waiting, then the no-op command and its data.
    task automatic test_reset_state();
        send_byte(OP_READ, 8'h00, '0, 1'b1);
        send_byte(OP_WRITE, CMD_AWAIT, '0, 1'b1);
        send_byte(OP_WRITE, CMD_AWAIT, '1, 1'b1);
        send_byte(OP_WRITE, CMD_NONE, '0, 1'b1);
        send_byte(OP_WRITE, 8'hFF, '1, 1'b1);
    endtask

    // The output, polarity and direction commands, with data at both extremes and alternating bits.
    task automatic test_known_commands();
        send_byte(OP_WRITE, CMD_DIRECTION, '0, 1'b1);
        send_byte(OP_WRITE, 8'h00, '1, 1'b1);
        send_byte(OP_WRITE, CMD_OUTPUT, '0, 1'b1);
        send_byte(OP_WRITE, 8'hA5, 8'h5A, 1'b1);
        send_byte(OP_WRITE, CMD_POLARITY, '0, 1'b1);
        send_byte(OP_WRITE, 8'hFF, '0, 1'b1);
        send_byte(OP_WRITE, CMD_OUTPUT, '1, 1'b1);
        send_byte(OP_WRITE, 8'h00, '1, 1'b1);
        send_byte(OP_WRITE, CMD_DIRECTION, '0, 1'b1);
        send_byte(OP_WRITE, 8'hF0, '0, 1'b1);
        send_byte(OP_WRITE, CMD_OUTPUT, '0, 1'b1);
        send_byte(OP_WRITE, 8'h5A, 8'hA5, 1'b1);
        // Reads: a changed value pulses the interrupt, a repeated one does not.
        send_byte(OP_READ, 8'hFF, 8'h5A, 1'b1);
        send_byte(OP_READ, 8'h00, 8'h5A, 1'b1);
        send_byte(OP_READ, 8'h00, 8'hA5, 1'b1);
    endtask

    // Unknown command stays selected until a read clears the pointer.
    task automatic test_unknown_command();
        send_byte(OP_WRITE, 8'h7E, '0, 1'b1);
        send_byte(OP_WRITE, 8'h12, '0, 1'b1);
        send_byte(OP_WRITE, 8'h03, '1, 1'b1);
        send_byte(OP_READ, 8'h00, '1, 1'b1);
        send_byte(OP_WRITE, CMD_DIRECTION, '0, 1'b1);
        send_byte(OP_WRITE, 8'hFF, '0, 1'b1);
    endtask

    // With the supply off, nothing is acknowledged and no state moves.
    task automatic test_power_off();
        send_byte(OP_WRITE, CMD_POLARITY, '0, 1'b1);
        send_byte(OP_WRITE, 8'h3C, '0, 1'b0);
        send_byte(OP_READ, 8'h00, '1, 1'b0);
        send_byte(OP_WRITE, 8'hC3, '0, 1'b1);
    endtask

    // Mostly well-formed command/data pairs and reads, with some noise.
    task automatic test_random_traffic();
        int target;
        int sel;
        int n;
        logic [7:0] cmd;
        target = bytes_sent + N_RANDOM;
        while (bytes_sent < target)
        begin
            // Rotate the idle pattern, including stretches with no idling at all.
            case ((bytes_sent / 200) % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 30;
                end
                2:
                begin
                    send_idle_pct = 70;
                    recv_idle_pct = 10;
                end
                default:
                begin
                    send_idle_pct = 10;
                    recv_idle_pct = 70;
                end
            endcase
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                n = $urandom_range(0, 9);
                cmd = (n < 4) ? CMD_OUTPUT : (n < 7) ? CMD_DIRECTION :
                      (n < 9) ? CMD_POLARITY : CMD_NONE;
                send_random_pins(OP_WRITE, cmd);
                send_random_pins(OP_WRITE, 8'($urandom));
            end
            else if (sel < 80)
            begin
                repeat ($urandom_range(1, 3))
                    send_random_pins(OP_READ, 8'($urandom));
            end
            else if (sel < 88)
            begin
                send_random_pins(OP_WRITE, 8'($urandom_range(4, 254)));
                repeat ($urandom_range(1, 3))
                    send_random_pins(OP_WRITE, 8'($urandom));
                send_random_pins(OP_READ, 8'($urandom));
            end
            else if (sel < 93)
            begin
                send_random_pins(OP_WRITE, CMD_AWAIT);
                send_random_pins(OP_WRITE, 8'($urandom_range(0, 3)));
                send_random_pins(OP_WRITE, 8'($urandom));
            end
            else
            begin
                send_random_pins(1'($urandom_range(0, 1)), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        recv_stall_left = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        error_count = 0;
        bytes_sent = 0;
        results_seen = 0;
        reads_seen = 0;
        irq_seen = 0;
        cmd_err_seen = 0;
        cycle_count = 0;
        last_pins = '0;
        pred_pointer = CMD_AWAIT;
        pred_polarity = '0;
        pred_direction = '1;
        pred_last_read = '0;
        pred_levels = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        send_idle_pct = 40;
        recv_idle_pct = 40;
        test_known_commands();
        test_unknown_command();
        test_power_off();
        test_random_traffic();

        @(negedge clk);
        s_tvalid = 1'b0;

        // Drain the remaining results, then keep watching for stray output.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bus bytes (%0d reads) and checked %0d results",
                 bytes_sent, reads_seen, results_seen);
        $display("Interrupt pulses predicted: %0d, command errors predicted: %0d",
                 irq_seen, cmd_err_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/i2cgx_pkg.sv
src/i2cgx_core.sv
src/i2cgx_regs.sv
src/i2c_gpio_expander_registers_unit.sv
tb/sv/tb_i2c_gpio_expander_registers_unit.sv
